/* rtl/nmea_sentence_framer_checker_defines.svh */
// Assertion macros used by the framer and checker RTL.
// Each macro expects clk and rst_n to exist in the scope that uses it.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nsfc_pkg.sv */
package nsfc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GSV = 24'h475356;
    localparam logic [23:0] TAG_GSA = 24'h475341;
    localparam logic [23:0] TAG_VTG = 24'h565447;

    localparam logic [5:0] NEED_GGA = 6'd10;
    localparam logic [5:0] NEED_RMC = 6'd10;
    localparam logic [5:0] NEED_GSV = 6'd4;
    localparam logic [5:0] NEED_GSA = 6'd18;
    localparam logic [5:0] NEED_VTG = 6'd8;

    localparam logic [5:0] COMMA_MAX   = 6'd62;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;
    localparam logic [3:0] DIGIT_LIMIT = 4'd8;
    localparam logic [1:0] TAG_FULL    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECKSUM  = 2'd1;
    localparam logic [1:0] ST_SHORT_TAG = 2'd2;
    localparam logic [1:0] ST_FEW_FIELDS = 2'd3;

    localparam logic [2:0] TYPE_OTHER = 3'd0;
    localparam logic [2:0] TYPE_GGA   = 3'd1;
    localparam logic [2:0] TYPE_RMC   = 3'd2;
    localparam logic [2:0] TYPE_GSV   = 3'd3;
    localparam logic [2:0] TYPE_GSA   = 3'd4;
    localparam logic [2:0] TYPE_VTG   = 3'd5;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_BODY = 2'd1,
        MODE_STAR = 2'd2
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic        cr_pending;
        logic [7:0]  running_xor;
        logic        tag_finished;
        logic [1:0]  tag_length;
        logic [23:0] tag_tail;
        logic [5:0]  comma_total;
        logic [7:0]  expected_sum;
        logic [3:0]  digit_total;
        logic        digits_bad;
    } scan_state_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] sentence_type;
        logic [5:0] field_count;
        logic [7:0] computed_sum;
    } result_t;

    localparam scan_state_t STATE_CLEAR = '{
        mode: MODE_HUNT, cr_pending: 1'b0, running_xor: 8'h00, tag_finished: 1'b0,
        tag_length: 2'd0, tag_tail: 24'h000000, comma_total: 6'd0,
        expected_sum: 8'h00, digit_total: 4'd0, digits_bad: 1'b0
    };

    // Returns {invalid, value}.
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            r = {1'b0, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            r = {1'b0, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

    // Folds one content byte into the sentence state (body or checksum text).
    function automatic scan_state_t take_content(scan_state_t s, logic [7:0] b);
        scan_state_t r;
        logic [4:0]  hv;
        r  = s;
        hv = hex_value(b);
        if (s.mode == MODE_BODY) begin
            if (b == CH_STAR) begin
                r.tag_finished = 1'b1;
                r.mode         = MODE_STAR;
            end else begin
                r.running_xor = s.running_xor ^ b;
                if (b == CH_COMMA) begin
                    r.tag_finished = 1'b1;
                    if (s.comma_total < COMMA_MAX) begin
                        r.comma_total = s.comma_total + 6'd1;
                    end
                end else if (!s.tag_finished) begin
                    r.tag_tail = {s.tag_tail[15:0], b};
                    if (s.tag_length != TAG_FULL) begin
                        r.tag_length = s.tag_length + 2'd1;
                    end
                end
            end
        end else begin
            if (hv[4]) begin
                r.digits_bad = 1'b1;
            end else begin
                r.expected_sum = {s.expected_sum[3:0], hv[3:0]};
                if (s.digit_total < DIGIT_MAX) begin
                    r.digit_total = s.digit_total + 4'd1;
                end
                if (r.digit_total > DIGIT_LIMIT) begin
                    r.digits_bad = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/nsfc_classify.sv */
module nsfc_classify
    import nsfc_pkg::*;
(
    input  scan_state_t st,
    output result_t     res
);

    logic [5:0] fields;
    logic [5:0] need;
    logic [2:0] stype;

    assign fields = st.comma_total + 6'd1;

    always_comb
    begin
        stype = TYPE_OTHER;
        need  = 6'd0;
        if (st.tag_length == TAG_FULL) begin
            priority if (st.tag_tail == TAG_GGA) begin
                stype = TYPE_GGA;
                need  = NEED_GGA;
            end else if (st.tag_tail == TAG_RMC) begin
                stype = TYPE_RMC;
                need  = NEED_RMC;
            end else if (st.tag_tail == TAG_GSV) begin
                stype = TYPE_GSV;
                need  = NEED_GSV;
            end else if (st.tag_tail == TAG_GSA) begin
                stype = TYPE_GSA;
                need  = NEED_GSA;
            end else if (st.tag_tail == TAG_VTG) begin
                stype = TYPE_VTG;
                need  = NEED_VTG;
            end else begin
                stype = TYPE_OTHER;
                need  = 6'd0;
            end
        end
    end

    always_comb
    begin
        res.sentence_type = stype;
        res.field_count   = fields;
        res.computed_sum  = st.running_xor;
        priority if (st.mode != MODE_STAR || st.digits_bad || st.digit_total == 4'd0
                     || st.running_xor != st.expected_sum) begin
            res.status = ST_CHECKSUM;
        end else if (st.tag_length != TAG_FULL) begin
            res.status = ST_SHORT_TAG;
        end else if (fields < need) begin
            res.status = ST_FEW_FIELDS;
        end else begin
            res.status = ST_OK;
        end
    end

endmodule

/* rtl/nsfc_scan.sv */
module nsfc_scan
    import nsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] byte_in,
    output logic       ends,
    output result_t    res
);

    scan_state_t st_reg;
    scan_state_t st_next;
    scan_state_t work;
    logic        in_sentence;

    // A CR held from the last byte plus an LF now closes the sentence.
    assign in_sentence = (st_reg.mode == MODE_BODY) || (st_reg.mode == MODE_STAR);
    assign ends        = in_sentence && st_reg.cr_pending && (byte_in == CH_LF);

    nsfc_classify u_classify (
        .st  (st_reg),
        .res (res)
    );

    always_comb
    begin
        work    = st_reg;
        st_next = st_reg;
        if (!in_sentence) begin
            if (byte_in == CH_DOLLAR) begin
                st_next      = STATE_CLEAR;
                st_next.mode = MODE_BODY;
            end
        end else if (ends) begin
            st_next = STATE_CLEAR;
        end else begin
            if (st_reg.cr_pending) begin
                work.cr_pending = 1'b0;
                work = take_content(work, CH_CR);
            end
            if (byte_in == CH_CR) begin
                work.cr_pending = 1'b1;
            end else begin
                work = take_content(work, byte_in);
            end
            st_next = work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= STATE_CLEAR;
        end else if (take) begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/nmea_sentence_framer_checker.sv */
// Path: a closing LF moves from the input register through the scanner into the result
// register, which drives out_valid; a full result register can stall the input stage.
// Throughput: one byte per cycle; the input stage stalls only when a closing LF meets a
// result still held in the output register.
// Reset: rst_n is asynchronous, active low; it empties both stages and returns the scanner
// to hunting for a dollar sign with all sentence state cleared.
module nmea_sentence_framer_checker
    import nsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [2:0] sentence_type,
    output logic [5:0] field_count,
    output logic [7:0] computed_sum
);

`include "nmea_sentence_framer_checker_defines.svh"

    // Input register: holds one received byte until the scanner takes it.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register: holds one finished sentence report until its transfer.
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       ends;
    logic       out_free;
    logic       consume;
    result_t    scan_res;

    // The scanner updates its state from the byte in the input register. Every byte
    // except a closing LF moves on at once; a closing LF also needs room in the result
    // register, which is free when empty or when its report transfers this cycle.
    nsfc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (consume),
        .byte_in (in_byte_reg),
        .ends    (ends),
        .res     (scan_res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign consume  = in_valid_reg && (!ends || out_free);
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (consume && ends) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // The report is taken from the state as it stood before the LF cleared it.
    always_ff @(posedge clk)
    begin
        if (consume && ends) begin
            out_res_reg <= scan_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign sentence_type = out_res_reg.sentence_type;
    assign field_count   = out_res_reg.field_count;
    assign computed_sum  = out_res_reg.computed_sum;

    // A sentence that closes must leave a report in the result register.
    `NSFC_ASSERT_NEXT(a_close_reports, consume && ends, out_valid_reg, "closed sentence lost")
    // The input stage may only hold its byte for a blocked report.
    `NSFC_ASSERT_NOW(a_stall_cause, in_valid_reg && !consume,
        ends && out_valid_reg && !out_ready, "input stage stalled without cause")
    // An empty input stage always takes a new byte.
    `NSFC_ASSERT_NOW(a_empty_ready, !in_valid_reg, in_ready, "empty input stage not ready")

endmodule

/* dv/tb_nmea_sentence_framer_checker.sv */
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_checker;
    import nsfc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 1700;
    localparam int MIN_SENTENCES  = 48;
    // The longest quiet stretch in a correct run is the deliberate receiver
    // hold-off plus one long sender gap. The watchdog allows several times that.
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    // A result passes through the input and result registers after its closing LF, so a short drain is enough.
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;

    // Ways of writing the checksum text after the body of a generated sentence.
    typedef enum int {
        SUM_GOOD,
        SUM_LOWER,
        SUM_WRONG,
        SUM_NONE,
        SUM_EMPTY,
        SUM_ONE,
        SUM_EIGHT,
        SUM_NINE,
        SUM_JUNK,
        SUM_STRAY_CR
    } sum_style_t;

    // Tracks the sentence being scanned from the bytes the block accepts and
    // keeps the results that closed sentences must produce, oldest first.
    class sentence_scoreboard;
        scan_mode_t  mode;
        logic        cr_held;
        logic [7:0]  body_xor;
        logic        tag_done;
        logic [1:0]  tag_chars;
        logic [23:0] tag_last3;
        logic [5:0]  commas;
        logic [7:0]  star_value;
        logic [3:0]  star_digits;
        logic        star_bad;
        result_t     pending_results[$];
        int          failures;

        function new();
            failures = 0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            mode        = MODE_HUNT;
            cr_held     = 1'b0;
            body_xor    = 8'h00;
            tag_done    = 1'b0;
            tag_chars   = 2'd0;
            tag_last3   = 24'h000000;
            commas      = 6'd0;
            star_value  = 8'h00;
            star_digits = 4'd0;
            star_bad    = 1'b0;
        endfunction

        function void report(string msg);
            if (failures < REPORT_LIMIT) begin
                $display("[%0t] %s", $time, msg);
            end
            failures++;
        endfunction

        // One content byte: body text before the star, checksum text after it.
        function void fold_byte(logic [7:0] b);
            logic [3:0] nib;
            logic       is_hex;
            if (mode == MODE_BODY) begin
                if (b == CH_STAR) begin
                    tag_done = 1'b1;
                    mode     = MODE_STAR;
                end else begin
                    body_xor = body_xor ^ b;
                    if (b == CH_COMMA) begin
                        tag_done = 1'b1;
                        if (commas < COMMA_MAX) begin
                            commas = commas + 6'd1;
                        end
                    end else if (!tag_done) begin
                        tag_last3 = {tag_last3[15:0], b};
                        if (tag_chars != TAG_FULL) begin
                            tag_chars = tag_chars + 2'd1;
                        end
                    end
                end
            end else begin
                // Letters A-F and a-f both carry 1..6 in their low nibble.
                is_hex = 1'b1;
                nib    = 4'd0;
                if (b >= "0" && b <= "9") begin
                    nib = b[3:0];
                end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
                    nib = b[3:0] + 4'd9;
                end else begin
                    is_hex = 1'b0;
                end
                if (!is_hex) begin
                    star_bad = 1'b1;
                end else begin
                    star_value = {star_value[3:0], nib};
                    if (star_digits < DIGIT_MAX) begin
                        star_digits = star_digits + 4'd1;
                    end
                    if (star_digits > DIGIT_LIMIT) begin
                        star_bad = 1'b1;
                    end
                end
            end
        endfunction

        function void note_byte(logic [7:0] b);
            result_t    r;
            logic [5:0] need;
            // Outside a sentence only a dollar sign matters.
            if (mode != MODE_BODY && mode != MODE_STAR) begin
                if (b == CH_DOLLAR) begin
                    clear_sentence();
                    mode = MODE_BODY;
                end
                return;
            end
            if (cr_held) begin
                if (b == CH_LF) begin
                    r.sentence_type = TYPE_OTHER;
                    need            = 6'd0;
                    if (tag_chars == TAG_FULL) begin
                        case (tag_last3)
                            TAG_GGA: begin r.sentence_type = TYPE_GGA; need = NEED_GGA; end
                            TAG_RMC: begin r.sentence_type = TYPE_RMC; need = NEED_RMC; end
                            TAG_GSV: begin r.sentence_type = TYPE_GSV; need = NEED_GSV; end
                            TAG_GSA: begin r.sentence_type = TYPE_GSA; need = NEED_GSA; end
                            TAG_VTG: begin r.sentence_type = TYPE_VTG; need = NEED_VTG; end
                            default: ;
                        endcase
                    end
                    r.field_count  = commas + 6'd1;
                    r.computed_sum = body_xor;
                    if (mode != MODE_STAR || star_bad || star_digits == 4'd0
                        || body_xor != star_value) begin
                        r.status = ST_CHECKSUM;
                    end else if (tag_chars != TAG_FULL) begin
                        r.status = ST_SHORT_TAG;
                    end else if (r.field_count < need) begin
                        r.status = ST_FEW_FIELDS;
                    end else begin
                        r.status = ST_OK;
                    end
                    pending_results.push_back(r);
                    clear_sentence();
                    return;
                end
                // A CR without LF behind it is ordinary content.
                cr_held = 1'b0;
                fold_byte(CH_CR);
            end
            if (b == CH_CR) begin
                cr_held = 1'b1;
                return;
            end
            fold_byte(b);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result: status %0d type %0d fields %0d sum %02h",
                                 got.status, got.sentence_type, got.field_count,
                                 got.computed_sum));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                report($sformatf({"result mismatch: status %0d/%0d type %0d/%0d ",
                                  "fields %0d/%0d sum %02h/%02h (expected/actual)"},
                                 want.status, got.status, want.sentence_type,
                                 got.sentence_type, want.field_count, got.field_count,
                                 want.computed_sum, got.computed_sum));
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [2:0] sentence_type;
    logic [5:0] field_count;
    logic [7:0] computed_sum;

    sentence_scoreboard sb = new();

    int         results_seen  = 0;
    int         quiet_cycles  = 0;
    int         bytes_planned = 0;
    bit         sender_calm   = 1'b0;
    logic [7:0] plan[$];

    string known_tag[5]  = '{"GGA", "RMC", "GSV", "GSA", "VTG"};
    int    known_need[5] = '{10, 10, 4, 18, 8};

    nmea_sentence_framer_checker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sentence_type (sentence_type),
        .field_count   (field_count),
        .computed_sum  (computed_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Both channels are observed at the rising edge, where a transfer happens.
    // Inputs only move at the falling edge, so the values seen here are settled.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_byte(rx_byte);
            end
            if (out_valid && out_ready) begin
                sb.check_result(result_t'({status, sentence_type, field_count, computed_sum}));
                results_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // A hung block stops the run here.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("nmea_sentence_framer_checker verification failed");
        $finish;
    end

    // Sender gaps: mostly none or short, now and then a long one. Calm sentences
    // run back to back so that the block also sees one byte every cycle while it is ready.
    function automatic int sender_gap();
        int r;
        if (sender_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one byte and holds it until the transfer; returns at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic flush_plan();
        while (plan.size() > 0) begin
            send_byte(plan.pop_front());
        end
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end else if (lower) begin
            return 8'h57 + 8'(v);
        end
        return 8'h37 + 8'(v);
    endfunction

    function automatic logic [7:0] random_hex();
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    // Any byte that keeps a payload field inside its field.
    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_COMMA || b == CH_STAR || b == CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR || (b >= "0" && b <= "9") || (b >= "A" && b <= "F")
                   || (b >= "a" && b <= "f"));
        return b;
    endfunction

    // Wraps a body in a dollar sign, checksum text of the given style and,
    // unless the sentence is cut short, the closing CR LF.
    function automatic void frame_sentence(input logic [7:0] body[$], input sum_style_t style,
                                           input bit terminate);
        logic [7:0] body_sum;
        logic [7:0] wrong;
        body_sum = 8'h00;
        foreach (body[i]) begin
            body_sum = body_sum ^ body[i];
        end
        wrong = body_sum ^ 8'($urandom_range(1, 255));
        plan.push_back(CH_DOLLAR);
        foreach (body[i]) begin
            plan.push_back(body[i]);
        end
        if (style != SUM_NONE) begin
            plan.push_back(CH_STAR);
        end
        case (style)
            SUM_GOOD, SUM_STRAY_CR:
            begin
                plan.push_back(hex_char(body_sum[7:4], 1'b0));
                plan.push_back(hex_char(body_sum[3:0], 1'b0));
                // An extra CR before the real CR LF is a lone CR in the checksum text.
                if (style == SUM_STRAY_CR) begin
                    plan.push_back(CH_CR);
                end
            end
            SUM_LOWER:
            begin
                plan.push_back(hex_char(body_sum[7:4], 1'b1));
                plan.push_back(hex_char(body_sum[3:0], 1'b1));
            end
            SUM_WRONG:
            begin
                plan.push_back(hex_char(wrong[7:4], 1'b0));
                plan.push_back(hex_char(wrong[3:0], 1'b0));
            end
            SUM_ONE:
            begin
                plan.push_back(hex_char(body_sum[3:0], 1'b0));
            end
            SUM_EIGHT, SUM_NINE:
            begin
                // Leading digits shift out; only the last two are compared, but a ninth digit marks the checksum bad.
                repeat ((style == SUM_EIGHT) ? 6 : 7) plan.push_back(random_hex());
                plan.push_back(hex_char(body_sum[7:4], 1'b0));
                plan.push_back(hex_char(body_sum[3:0], 1'b1));
            end
            SUM_JUNK:
            begin
                plan.push_back(hex_char(body_sum[7:4], 1'b0));
                plan.push_back(junk_char());
                plan.push_back(hex_char(body_sum[3:0], 1'b0));
            end
            default: ;
        endcase
        if (terminate) begin
            plan.push_back(CH_CR);
            plan.push_back(CH_LF);
        end
    endfunction

    // Builds one random sentence, mostly well formed, sometimes preceded by line
    // noise, sometimes broken in its checksum text or never closed.
    function automatic void plan_sentence();
        logic [7:0] body[$];
        logic [7:0] b;
        string      prefix;
        int         pick;
        int         idx;
        int         need;
        int         n_commas;
        int         r;
        sum_style_t style;
        repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_DOLLAR && $urandom_range(0, 9) != 0) begin
                b = 8'h00;
            end
            plan.push_back(b);
        end
        need = 6;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            // A known talker tag, with or without a talker prefix.
            idx    = $urandom_range(0, 4);
            need   = known_need[idx];
            prefix = ($urandom_range(0, 1) != 0) ? "GP" : "GN";
            if ($urandom_range(0, 1) != 0) begin
                for (int i = 0; i < prefix.len(); i++) body.push_back(prefix[i]);
            end
            for (int i = 0; i < 3; i++) body.push_back(known_tag[idx][i]);
        end else if (pick == 6) begin
            repeat ($urandom_range(0, 2)) body.push_back(8'("A" + $urandom_range(0, 25)));
        end else if (pick == 7) begin
            repeat ($urandom_range(3, 6)) body.push_back(8'("A" + $urandom_range(0, 25)));
        end else begin
            repeat ($urandom_range(1, 4)) body.push_back(field_byte());
        end
        // Field counts cluster around each type's minimum, with some long
        // sentences that drive the comma count into saturation.
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n_commas = $urandom_range((need > 3) ? need - 3 : 0, need + 1);
        end else if (r < 90) begin
            n_commas = $urandom_range(0, 20);
        end else begin
            n_commas = $urandom_range(58, 66);
        end
        repeat (n_commas) begin
            body.push_back(CH_COMMA);
            repeat ((n_commas > 30) ? $urandom_range(0, 1) : $urandom_range(0, 3)) begin
                body.push_back(field_byte());
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            body.push_back(CH_CR);
            body.push_back("Z");
        end
        r = $urandom_range(0, 19);
        case (r)
            10: style = SUM_LOWER;
            11: style = SUM_WRONG;
            12: style = SUM_NONE;
            13: style = SUM_EMPTY;
            14: style = SUM_ONE;
            15: style = SUM_EIGHT;
            16: style = SUM_NINE;
            17: style = SUM_JUNK;
            18: style = SUM_STRAY_CR;
            default: style = SUM_GOOD;
        endcase
        frame_sentence(body, style, $urandom_range(0, 15) != 0);
    endfunction

    // Receiver: random stalls, short and long, with calm windows of constant
    // readiness. Once, after some results have come through, it holds off for
    // a long stretch so the output fills and the block stalls its input.
    initial
    begin
        int hold_left;
        int rx_cycle;
        int r;
        bit long_hold_done;
        out_ready      = 1'b0;
        hold_left      = 0;
        rx_cycle       = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (!long_hold_done && results_seen >= 10) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_ready      <= 1'b0;
            end else if (rx_cycle % 1000 < 150) begin
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    initial
    begin
        logic [7:0] body[$];
        string      text;
        int         sentences;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Line noise while hunting, including a stray LF and CR,
        // must produce nothing.
        plan.push_back(8'h00);
        plan.push_back(8'hFF);
        plan.push_back(CH_LF);
        plan.push_back(CH_CR);
        // An empty body with a matching checksum reports a short tag.
        frame_sentence(body, SUM_GOOD, 1'b1);
        // A dollar sign inside the body and a lone CR are both plain content;
        // three commas give GSV exactly its minimum field count.
        text = "GSV,$\r,,";
        for (int i = 0; i < text.len(); i++) body.push_back(text[i]);
        frame_sentence(body, SUM_GOOD, 1'b1);
        flush_plan();

        // Random part.
        sentences = 0;
        while (bytes_planned < RANDOM_BYTES || sentences < MIN_SENTENCES) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            plan_sentence();
            bytes_planned += plan.size();
            flush_plan();
            sentences++;
        end
        in_valid <= 1'b0;

        // Let every outstanding result arrive, then watch a little longer for
        // anything extra.
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0) begin
            $display("nmea_sentence_framer_checker verification clean");
        end else begin
            $display("nmea_sentence_framer_checker verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/nsfc_pkg.sv
rtl/nsfc_classify.sv
rtl/nsfc_scan.sv
rtl/nmea_sentence_framer_checker.sv
dv/tb_nmea_sentence_framer_checker.sv
